// ===== src/pid_deadzone_isep_filtered_d_assert.svh =====
// Assertion macros used by the checker module of the PID block.
`ifndef PID_DEADZONE_ISEP_FILTERED_D_ASSERT_SVH
`define PID_DEADZONE_ISEP_FILTERED_D_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PIDISEP_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIDISEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pidisep_pkg.sv =====
// Shared types and constants of the PID controller with dead band and integral separation.
`default_nettype none

package pidisep_pkg;

	localparam int IDX_W  = 4;
	localparam int DATA_W = 16;
	localparam int LIM_W  = 15;
	localparam int ERR_W  = 17;
	localparam int INT_W  = 24;
	localparam int DER_W  = 32;
	localparam int SPAN_W = 18;

	localparam int unsigned WRAP_SPAN_DEF = 0;

	localparam logic [IDX_W-1:0] REG_KP        = 4'd0;
	localparam logic [IDX_W-1:0] REG_KI        = 4'd1;
	localparam logic [IDX_W-1:0] REG_DGAIN     = 4'd2;
	localparam logic [IDX_W-1:0] REG_DKEEP     = 4'd3;
	localparam logic [IDX_W-1:0] REG_MAX_OUT   = 4'd4;
	localparam logic [IDX_W-1:0] REG_INT_LIMIT = 4'd5;
	localparam logic [IDX_W-1:0] REG_DEAD      = 4'd6;
	localparam logic [IDX_W-1:0] REG_ISEP      = 4'd7;

	localparam logic [LIM_W-1:0]  MAX_OUT_RST   = 15'h7FFF;
	localparam logic [LIM_W-1:0]  INT_LIMIT_RST = 15'h7FFF;
	localparam logic [DATA_W-1:0] ISEP_RST      = 16'hFFFF;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] kp;
		logic [DATA_W-1:0] ki;
		logic [DATA_W-1:0] deriv_gain;
		logic [DATA_W-1:0] deriv_keep;
		logic [LIM_W-1:0]  max_out;
		logic [LIM_W-1:0]  int_limit;
		logic [DATA_W-1:0] deadband;
		logic [DATA_W-1:0] sep_limit;
	} regs_t;

	typedef struct packed {
		logic                    clear;
		logic signed [ERR_W-1:0] err;
		logic                    dz;
		logic                    used;
	} err_t;

endpackage

`default_nettype wire

// ===== src/pid_deadzone_isep_filtered_d.sv =====
// Top level of the positional PID controller with dead band and integral separation.
//
//  port group  | flow  | handshake            | carries
//  in          | in    | in_valid / in_stall  | command, setpoint, feedback
//  out         | out   | out_valid / out_stall| drive, integral_used, saturated
//  cfg         | in    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle unless out_stall holds a full pipeline; an input transfer passes the
// input, error stage and output registers before out_valid rises.
// The integrator / derivative feedback closes inside the control-step stage.
// Reset is asynchronous: valids clear, registers return to defaults, loop state zero.
// in_stall rises only while out_stall holds a full pipeline; cfg_ready is always high.
`default_nettype none

module pid_deadzone_isep_filtered_d import pidisep_pkg::*; #(
	parameter int unsigned WRAP_SPAN = WRAP_SPAN_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     command,
	input  wire logic signed [DATA_W-1:0] setpoint,
	input  wire logic signed [DATA_W-1:0] feedback,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      drive,
	output logic                          integral_used,
	output logic                          saturated,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data
);

	regs_t regs;
	err_t  err_s2;

	logic                     valid_s1;
	logic                     valid_s2;
	logic                     valid_s3;
	logic                     command_s1;
	logic signed [DATA_W-1:0] setpoint_s1;
	logic signed [DATA_W-1:0] feedback_s1;
	logic                     adv1;
	logic                     adv2;
	logic                     adv3;
	logic                     accept;

	assign adv3     = ~valid_s3 | ~out_stall;
	assign adv2     = ~valid_s2 | adv3;
	assign adv1     = ~valid_s1 | adv2;
	assign in_stall = ~adv1;
	assign accept   = in_valid & adv1;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1)
				valid_s1 <= in_valid;
			if (adv2)
				valid_s2 <= valid_s1;
			if (adv3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1  <= command;
			setpoint_s1 <= setpoint;
			feedback_s1 <= feedback;
		end
	end

	pidisep_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	pidisep_err #(
		.WRAP_SPAN (WRAP_SPAN)
	) u_err (
		.clk         (clk),
		.ld          (valid_s1 & adv2),
		.command_s1  (command_s1),
		.setpoint_s1 (setpoint_s1),
		.feedback_s1 (feedback_s1),
		.regs        (regs),
		.err_s2      (err_s2)
	);

	pidisep_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.ld               (valid_s2 & adv3),
		.err_s2           (err_s2),
		.regs             (regs),
		.drive_s3         (drive),
		.integral_used_s3 (integral_used),
		.saturated_s3     (saturated)
	);

endmodule

`default_nettype wire

// ===== src/pidisep_cfg.sv =====
// Configuration register file of the PID block.
`default_nettype none

module pidisep_cfg import pidisep_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	output regs_t                  regs
);

	regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp         <= '0;
			regs_q.ki         <= '0;
			regs_q.deriv_gain <= '0;
			regs_q.deriv_keep <= '0;
			regs_q.max_out    <= MAX_OUT_RST;
			regs_q.int_limit  <= INT_LIMIT_RST;
			regs_q.deadband   <= '0;
			regs_q.sep_limit  <= ISEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KP:        regs_q.kp         <= cfg_data;
				REG_KI:        regs_q.ki         <= cfg_data;
				REG_DGAIN:     regs_q.deriv_gain <= cfg_data;
				REG_DKEEP:     regs_q.deriv_keep <= cfg_data;
				REG_MAX_OUT:   regs_q.max_out    <= cfg_data[LIM_W-1:0];
				REG_INT_LIMIT: regs_q.int_limit  <= cfg_data[LIM_W-1:0];
				REG_DEAD:      regs_q.deadband   <= cfg_data;
				REG_ISEP:      regs_q.sep_limit  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/pidisep_err.sv =====
// Error stage: difference, optional wrap, dead band and separation test.
`default_nettype none

module pidisep_err import pidisep_pkg::*; #(
	parameter int unsigned WRAP_SPAN = WRAP_SPAN_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     ld,
	input  wire logic                     command_s1,
	input  wire logic signed [DATA_W-1:0] setpoint_s1,
	input  wire logic signed [DATA_W-1:0] feedback_s1,
	input  regs_t                         regs,
	output err_t                          err_s2
);

	localparam logic signed [SPAN_W-1:0] SPAN = SPAN_W'(WRAP_SPAN);

	logic signed [ERR_W-1:0]  diff;
	logic signed [SPAN_W-1:0] diff_x;
	logic signed [SPAN_W-1:0] diff2;
	logic signed [ERR_W-1:0]  wrapped;
	logic        [ERR_W-1:0]  mag;
	logic                     dz;
	err_t                     err_d;

	always_comb begin
		diff   = {setpoint_s1[DATA_W-1], setpoint_s1} - {feedback_s1[DATA_W-1], feedback_s1};
		diff_x = {diff[ERR_W-1], diff};
		diff2  = {diff, 1'b0};
		wrapped = diff;
		if (WRAP_SPAN != 0) begin
			// single fold into about +-span/2
			if (diff2 > SPAN)
				wrapped = ERR_W'(diff_x - SPAN);
			else if (diff2 < -SPAN)
				wrapped = ERR_W'(diff_x + SPAN);
		end
		mag = wrapped[ERR_W-1] ? ERR_W'(-wrapped) : ERR_W'(wrapped);
		dz  = mag < {1'b0, regs.deadband};

		err_d.clear = (command_s1 == CMD_CLEAR);
		err_d.dz    = dz;
		err_d.err   = dz ? '0 : wrapped;
		err_d.used  = dz | (mag <= {1'b0, regs.sep_limit});
	end

	always_ff @(posedge clk) begin
		if (ld)
			err_s2 <= err_d;
	end

endmodule

`default_nettype wire

// ===== src/pidisep_core.sv =====
// Control step: P, clamped integrator, filtered derivative, output clamp, loop state.
`default_nettype none

module pidisep_core import pidisep_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    ld,
	input  err_t                         err_s2,
	input  regs_t                        regs,
	output logic signed [DATA_W-1:0]     drive_s3,
	output logic                         integral_used_s3,
	output logic                         saturated_s3
);

	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [INT_W-1:0] integ_q;
	logic signed [DER_W-1:0] lastd_q;

	logic signed [ERR_W-1:0] prev_eff;
	logic signed [33:0]      p;
	logic signed [33:0]      ki_e;
	logic signed [34:0]      isum;
	logic signed [34:0]      ilim;
	logic signed [34:0]      iclamp;
	logic signed [INT_W-1:0] integ_nx;
	logic signed [ERR_W:0]   de;
	logic signed [34:0]      dg;
	logic signed [48:0]      kd;
	logic signed [48:0]      kd_r;
	logic signed [35:0]      dsum;
	logic signed [DER_W-1:0] d_nx;
	logic signed [35:0]      sum;
	logic signed [35:0]      olim;
	logic signed [35:0]      rnd;
	logic                    sat_hi;
	logic                    sat_lo;
	logic signed [DATA_W-1:0] drive_d;

	always_comb begin
		prev_eff = err_s2.dz ? '0 : prev_err_q;

		p    = $signed({1'b0, regs.kp}) * err_s2.err;
		ki_e = $signed({1'b0, regs.ki}) * err_s2.err;

		isum = {ki_e[33], ki_e} + {{(35-INT_W){integ_q[INT_W-1]}}, integ_q};
		ilim = $signed({12'b0, regs.int_limit, 8'b0});
		if (isum > ilim)
			iclamp = ilim;
		else if (isum < -ilim)
			iclamp = -ilim;
		else
			iclamp = isum;
		integ_nx = iclamp[INT_W-1:0];

		de   = {err_s2.err[ERR_W-1], err_s2.err} - {prev_eff[ERR_W-1], prev_eff};
		dg   = $signed({1'b0, regs.deriv_gain}) * de;
		kd   = $signed({1'b0, regs.deriv_keep}) * lastd_q;
		// Q.24 -> Q.8, half rounds up
		kd_r = kd + 49'sd32768;
		dsum = {dg[34], dg} + {{3{kd_r[48]}}, kd_r[48:16]};
		if (dsum > 36'sh0_7FFF_FFFF)
			d_nx = 32'sh7FFF_FFFF;
		else if (dsum < -36'sh0_8000_0000)
			d_nx = 32'sh8000_0000;
		else
			d_nx = dsum[DER_W-1:0];

		sum = {{2{p[33]}}, p} + {{4{d_nx[DER_W-1]}}, d_nx}
			+ (err_s2.used ? {{(36-INT_W){integ_nx[INT_W-1]}}, integ_nx} : 36'sd0);
		olim   = $signed({13'b0, regs.max_out, 8'b0});
		sat_hi = sum > olim;
		sat_lo = sum < -olim;
		rnd    = sum + 36'sd128;
		if (sat_hi)
			drive_d = $signed({1'b0, regs.max_out});
		else if (sat_lo)
			drive_d = -$signed({1'b0, regs.max_out});
		else
			drive_d = rnd[23:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
			lastd_q    <= '0;
		end else if (ld) begin
			if (err_s2.clear) begin
				// derivative memory survives a clear
				prev_err_q <= '0;
				integ_q    <= '0;
			end else begin
				prev_err_q <= err_s2.err;
				integ_q    <= integ_nx;
				lastd_q    <= d_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			if (err_s2.clear) begin
				drive_s3         <= '0;
				integral_used_s3 <= 1'b0;
				saturated_s3     <= 1'b0;
			end else begin
				drive_s3         <= drive_d;
				integral_used_s3 <= err_s2.used;
				saturated_s3     <= sat_hi | sat_lo;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/pidisep_chk.sv =====
// Port-level checker of the PID block and its bind to the top level.
`default_nettype none
`include "pid_deadzone_isep_filtered_d_assert.svh"

module pidisep_chk import pidisep_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_stall,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic signed [DATA_W-1:0] drive,
	input wire logic                     saturated,
	input wire logic                     cfg_valid,
	input wire logic                     cfg_ready,
	input wire logic [IDX_W-1:0]         cfg_index,
	input wire logic [DATA_W-1:0]        cfg_data
);

	logic [LIM_W-1:0]         max_out_q;
	logic signed [DATA_W-1:0] pos_max;
	logic signed [DATA_W-1:0] neg_max;

	// shadow of the output limit, taken from register transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_out_q <= MAX_OUT_RST;
		else if (cfg_valid && cfg_ready && cfg_index == REG_MAX_OUT)
			max_out_q <= cfg_data[LIM_W-1:0];
	end

	assign pos_max = $signed({1'b0, max_out_q});
	assign neg_max = -pos_max;

	`PIDISEP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`PIDISEP_ASSERT(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a held result")
	`PIDISEP_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid, "result missing three cycles after transfer")
	`PIDISEP_ASSERT(a_sat_value, clk, arst_n, out_valid && saturated, drive == pos_max || drive == neg_max, "saturated drive not at limit")
	`PIDISEP_ASSERT(a_in_range, clk, arst_n, out_valid && !saturated, drive <= pos_max && drive >= neg_max, "drive beyond limit")

endmodule

bind pid_deadzone_isep_filtered_d pidisep_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive     (drive),
	.saturated (saturated),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);

`default_nettype wire

// ===== tb/sv/pid_deadzone_isep_filtered_d_test.sv =====
// Self-checking testbench for the fixed-point PID controller with dead band and integral separation.
`default_nettype none

module pid_deadzone_isep_filtered_d_test import pidisep_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 10;
	localparam int NUM_REGS    = REG_ISEP + 1;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 122;
	localparam int HOLD_CYCLES = 100;
	localparam int TAIL_CYCLES = 8;
	localparam int CYCLE_LIMIT = 300000;

	localparam int MODE_MAX  = 0;
	localparam int MODE_MIN  = 1;
	localparam int MODE_MILD = 2;
	localparam int MODE_WILD = 3;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     used;
		logic                     sat;
	} drive_t;

	// Tracks loop state and register values, predicts one result per transfer.
	class drive_scoreboard;
		localparam longint DER_MAX = 2147483647;
		localparam longint DER_MIN = -DER_MAX - 1;

		regs_t  cfg;
		longint prev_err;
		longint integ;
		longint last_d;
		drive_t drive_q[$];
		int     n_steps;
		int     n_clears;
		int     n_checked;
		int     n_errors;

		function new();
			cfg = '0;
			cfg.max_out = MAX_OUT_RST;
			cfg.int_limit = INT_LIMIT_RST;
			cfg.sep_limit = ISEP_RST;
			prev_err = 0;
			integ = 0;
			last_d = 0;
			n_steps = 0;
			n_clears = 0;
			n_checked = 0;
			n_errors = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_KP:        cfg.kp = val;
				REG_KI:        cfg.ki = val;
				REG_DGAIN:     cfg.deriv_gain = val;
				REG_DKEEP:     cfg.deriv_keep = val;
				REG_MAX_OUT:   cfg.max_out = val[LIM_W-1:0];
				REG_INT_LIMIT: cfg.int_limit = val[LIM_W-1:0];
				REG_DEAD:      cfg.deadband = val;
				REG_ISEP:      cfg.sep_limit = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return drive_q.size();
		endfunction

		function void note_input(logic cmd, logic signed [DATA_W-1:0] sp,
				logic signed [DATA_W-1:0] fb);
			longint e, ae, span, ilim, d, sum, lim;
			drive_t r;
			r = '0;
			if (cmd == CMD_CLEAR) begin
				// derivative memory survives a clear
				prev_err = 0;
				integ = 0;
				n_clears++;
				drive_q.push_back(r);
				return;
			end
			n_steps++;
			e = longint'(sp) - longint'(fb);
			if (WRAP_SPAN_DEF != 0) begin
				span = longint'(WRAP_SPAN_DEF);
				if (2 * e > span)
					e -= span;
				else if (2 * e < -span)
					e += span;
			end
			ae = (e < 0) ? -e : e;
			if (ae < longint'(cfg.deadband)) begin
				e = 0;
				ae = 0;
				prev_err = 0;
			end
			r.used = (ae <= longint'(cfg.sep_limit));

			ilim = longint'(cfg.int_limit) * 256;
			integ = integ + longint'(cfg.ki) * e;
			if (integ > ilim)
				integ = ilim;
			else if (integ < -ilim)
				integ = -ilim;

			d = longint'(cfg.deriv_gain) * (e - prev_err)
				+ ((longint'(cfg.deriv_keep) * last_d + 32768) >>> 16);
			if (d > DER_MAX)
				d = DER_MAX;
			else if (d < DER_MIN)
				d = DER_MIN;

			sum = longint'(cfg.kp) * e + (r.used ? integ : 0) + d;
			lim = longint'(cfg.max_out) * 256;
			if (sum > lim) begin
				r.drive = {1'b0, cfg.max_out};
				r.sat = 1'b1;
			end else if (sum < -lim) begin
				r.drive = DATA_W'(-longint'(cfg.max_out));
				r.sat = 1'b1;
			end else begin
				r.drive = DATA_W'((sum + 128) >>> 8);
			end

			prev_err = e;
			last_d = d;
			drive_q.push_back(r);
		endfunction

		function void check_drive(logic signed [DATA_W-1:0] drv, logic used, logic sat);
			drive_t want;
			if (drive_q.size() == 0) begin
				$display("%0t: unexpected result: drive %0d integral_used %0b saturated %0b",
					$time, drv, used, sat);
				n_errors++;
				return;
			end
			want = drive_q.pop_front();
			n_checked++;
			if (drv !== want.drive) begin
				$display("%0t: drive mismatch: expected %0d, actual %0d", $time, want.drive, drv);
				n_errors++;
			end
			if (used !== want.used) begin
				$display("%0t: integral_used mismatch: expected %0b, actual %0b",
					$time, want.used, used);
				n_errors++;
			end
			if (sat !== want.sat) begin
				$display("%0t: saturated mismatch: expected %0b, actual %0b",
					$time, want.sat, sat);
				n_errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     command;
	logic signed [DATA_W-1:0] setpoint;
	logic signed [DATA_W-1:0] feedback;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] drive;
	logic                     integral_used;
	logic                     saturated;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [IDX_W-1:0]         cfg_index;
	logic [DATA_W-1:0]        cfg_data;

	drive_scoreboard   sb = new();
	logic [DATA_W-1:0] cfg_vals [NUM_REGS];
	bit                rx_idle = 1'b0;
	bit                hold_req = 1'b0;
	int                err_walk = 0;
	int                cycles = 0;

	pid_deadzone_isep_filtered_d #(
		.WRAP_SPAN(WRAP_SPAN_DEF)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.setpoint     (setpoint),
		.feedback     (feedback),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive        (drive),
		.integral_used(integral_used),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("pid_deadzone_isep_filtered_d verification failed");
			$finish;
		end
	end

	// results are checked before the same edge's input transfer is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_drive(drive, integral_used, saturated);
			if (in_valid && !in_stall)
				sb.note_input(command, setpoint, feedback);
		end
	end

	// receiver back-pressure: random bursts, plus one long hold on request
	initial begin : rx_stall_gen
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 10);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// leaves in_valid high; the caller lowers it when a gap follows
	task automatic send_item(logic cmd, logic signed [DATA_W-1:0] sp,
			logic signed [DATA_W-1:0] fb);
		in_valid <= 1'b1;
		command <= cmd;
		setpoint <= sp;
		feedback <= fb;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_cfg();
		int i;
		for (i = REG_KP; i <= REG_ISEP; i++)
			write_reg(i[IDX_W-1:0], cfg_vals[i]);
		// an index past the register list must be ignored
		write_reg(IDX_W'(REG_ISEP + 1 + $urandom_range(0, 7)),
			DATA_W'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
	endtask

	// the first edge lets the last accepted item reach the scoreboard
	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic void pick_cfg(int mode);
		int i;
		case (mode)
			MODE_MAX: begin
				for (i = 0; i < NUM_REGS; i++)
					cfg_vals[i] = '1;
				cfg_vals[REG_DEAD] = '0;
			end
			MODE_MIN: begin
				for (i = 0; i < NUM_REGS; i++)
					cfg_vals[i] = '0;
				cfg_vals[REG_DEAD] = '1;
			end
			MODE_MILD: begin
				cfg_vals[REG_KP] = DATA_W'($urandom_range(0, 1024));
				cfg_vals[REG_KI] = DATA_W'($urandom_range(0, 256));
				cfg_vals[REG_DGAIN] = DATA_W'($urandom_range(0, 1024));
				cfg_vals[REG_DKEEP] = DATA_W'($urandom_range(0, 65535));
				cfg_vals[REG_MAX_OUT] = DATA_W'($urandom_range(0, 65535));
				cfg_vals[REG_INT_LIMIT] = DATA_W'($urandom_range(0, 65535));
				cfg_vals[REG_DEAD] = DATA_W'($urandom_range(0, 20));
				cfg_vals[REG_ISEP] = DATA_W'($urandom_range(0, 400));
			end
			default: begin
				for (i = 0; i < NUM_REGS; i++)
					cfg_vals[i] = DATA_W'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	task automatic run_random(int n_items, bit may_idle);
		int  k, pick, delta, sp, fb;
		bit  idle_now;
		logic cmd;
		idle_now = 1'b0;
		for (k = 0; k < n_items; k++) begin
			if (k % 40 == 0) begin
				idle_now = may_idle && ($urandom_range(0, 2) != 0);
				rx_idle = idle_now;
			end
			pick = $urandom_range(0, 99);
			cmd = (pick < 3) ? CMD_CLEAR : CMD_STEP;
			fb = int'($urandom_range(0, 65535)) - 32768;
			if (pick < 80) begin
				if (pick < 55) begin
					// slowly drifting error keeps the integrator moving one way
					err_walk += int'($urandom_range(0, 40)) - 20;
					if (err_walk > 3000)
						err_walk = 3000;
					else if (err_walk < -3000)
						err_walk = -3000;
					delta = err_walk;
				end else begin
					case ($urandom_range(0, 3))
						0: delta = int'(sb.cfg.deadband) - 1;
						1: delta = int'(sb.cfg.deadband);
						2: delta = int'(sb.cfg.sep_limit);
						default: delta = int'(sb.cfg.sep_limit) + 1;
					endcase
					if (delta > 32767)
						delta = 32767;
					if ($urandom_range(0, 1) == 1)
						delta = -delta;
				end
				sp = fb + delta;
				if (sp > 32767 || sp < -32768)
					sp = fb - delta;
			end else begin
				sp = int'($urandom_range(0, 65535)) - 32768;
			end
			send_item(cmd, sp[DATA_W-1:0], fb[DATA_W-1:0]);
			if (idle_now && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		rx_idle = 1'b0;
	endtask

	initial begin : main_seq
		int ph;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_STEP;
		setpoint <= '0;
		feedback <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_KP;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: zero gains, so drive stays zero
		send_item(CMD_STEP, 16'sh7FFF, -16'sh8000);
		send_item(CMD_STEP, 16'sd1234, -16'sd77);
		in_valid <= 1'b0;
		wait_drained();

		cfg_vals[REG_KP] = 16'h0180;
		cfg_vals[REG_KI] = 16'h0020;
		cfg_vals[REG_DGAIN] = 16'h0100;
		cfg_vals[REG_DKEEP] = 16'hC000;
		cfg_vals[REG_MAX_OUT] = 16'd2000;
		cfg_vals[REG_INT_LIMIT] = 16'd300;
		cfg_vals[REG_DEAD] = 16'd4;
		cfg_vals[REG_ISEP] = 16'd100;
		apply_cfg();

		send_item(CMD_CLEAR, 16'sd0, 16'sd0);
		send_item(CMD_STEP, 16'sd0, 16'sd0);
		send_item(CMD_STEP, 16'sh7FFF, -16'sh8000);   // largest positive error
		send_item(CMD_STEP, -16'sh8000, 16'sh7FFF);   // largest negative error
		send_item(CMD_STEP, 16'sd3, 16'sd0);          // inside dead band
		send_item(CMD_STEP, 16'sd0, 16'sd3);
		send_item(CMD_STEP, 16'sd4, 16'sd0);          // dead band edge passes
		send_item(CMD_STEP, 16'sd0, 16'sd4);
		send_item(CMD_STEP, 16'sd100, 16'sd0);        // separation edge, integral kept
		send_item(CMD_STEP, 16'sd101, 16'sd0);        // just past separation
		send_item(CMD_STEP, 16'sd0, 16'sd100);
		send_item(CMD_STEP, 16'sd0, 16'sd101);
		send_item(CMD_CLEAR, 16'sd555, -16'sd999);    // fields ignored, derivative kept
		send_item(CMD_STEP, 16'sd50, 16'sd0);
		send_item(CMD_STEP, 16'sd0, 16'sd0);
		send_item(CMD_STEP, 16'sd90, 16'sd0);
		send_item(CMD_STEP, 16'sd90, 16'sd0);
		send_item(CMD_STEP, 16'sd90, 16'sd0);         // integrator still below its clamp
		send_item(CMD_STEP, -16'sh8000, -16'sh8000);
		send_item(CMD_STEP, 16'sh7FFF, 16'sh7FFF);
		send_item(CMD_STEP, 16'sd2, -16'sd1);         // inside dead band again
		in_valid <= 1'b0;
		wait_drained();

		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0, 6: pick_cfg(MODE_MAX);
				1:    pick_cfg(MODE_MIN);
				2, 4: pick_cfg(MODE_MILD);
				default: pick_cfg(MODE_WILD);
			endcase
			apply_cfg();
			if (ph == 3)
				hold_req = 1'b1;
			run_random(PHASE_ITEMS, ph < N_PHASES - 2);
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d control steps and %0d clears through %0d register settings;",
			sb.n_steps, sb.n_clears, N_PHASES + 2);
		$display("%0d results checked, %0d mismatches, with random stalls and one long hold.",
			sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("pid_deadzone_isep_filtered_d verification clean");
		end else begin
			$display("pid_deadzone_isep_filtered_d verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
